@@ src/tlms_pkg.sv @@
package tlms_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int REG_WIDTH   = 16;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_WIDTH) - 64'd1;

    localparam logic [CFG_ADDR_W-1:0] REG_RED     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_YELLOW  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ALARM   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFLINE = 3'd4;

    localparam logic [REG_WIDTH-1:0] RED_RESET     = 16'd3000;
    localparam logic [REG_WIDTH-1:0] YELLOW_RESET  = 16'd500;
    localparam logic [REG_WIDTH-1:0] GREEN_RESET   = 16'd1000;
    localparam logic [REG_WIDTH-1:0] ALARM_RESET   = 16'd1000;
    localparam logic [REG_WIDTH-1:0] OFFLINE_RESET = 16'd500;

    localparam logic [2:0] LAMP_OFF = 3'b000;
    localparam logic [2:0] LAMP_R   = 3'b001;
    localparam logic [2:0] LAMP_Y   = 3'b010;
    localparam logic [2:0] LAMP_G   = 3'b100;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_OFFLINE = 2'd1,
        MODE_ALARM   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_RED    = 2'd0,
        PH_YELLOW = 2'd1,
        PH_GREEN  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [REG_WIDTH-1:0] red;
        logic [REG_WIDTH-1:0] yellow;
        logic [REG_WIDTH-1:0] green;
        logic [REG_WIDTH-1:0] alarm;
        logic [REG_WIDTH-1:0] offline;
    } t_durations;

    typedef struct packed {
        t_mode      mode;
        logic       changed;
        logic [2:0] lamps;
    } t_result;

    function automatic logic [TIMER_WIDTH-1:0] clip_duration(input logic [REG_WIDTH-1:0] d);
        logic [63:0] wide;
        wide = 64'(d);
        if (wide > TIMER_MAX) begin
            return TIMER_WIDTH'(TIMER_MAX);
        end
        return TIMER_WIDTH'(wide);
    endfunction

endpackage

@@ src/tlms_cfg_regs.sv @@
module tlms_cfg_regs
    import tlms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [REG_WIDTH-1:0]  i_cfg_wdata,
    output t_durations            o_durations
);

    t_durations r_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur.red     <= RED_RESET;
            r_dur.yellow  <= YELLOW_RESET;
            r_dur.green   <= GREEN_RESET;
            r_dur.alarm   <= ALARM_RESET;
            r_dur.offline <= OFFLINE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RED:     r_dur.red     <= i_cfg_wdata;
                REG_YELLOW:  r_dur.yellow  <= i_cfg_wdata;
                REG_GREEN:   r_dur.green   <= i_cfg_wdata;
                REG_ALARM:   r_dur.alarm   <= i_cfg_wdata;
                REG_OFFLINE: r_dur.offline <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_durations = r_dur;

endmodule

@@ src/tlms_seq.sv @@
module tlms_seq
    import tlms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [2:0] i_switch_n,
    input  t_durations i_durations,
    output t_result    o_result
);

    t_mode                  r_mode, n_mode;
    t_phase                 r_phase, n_phase;
    logic [2:0]             r_lamps, n_lamps;
    logic [TIMER_WIDTH-1:0] r_remaining, n_remaining;
    logic                   r_first;

    t_mode                  sel_mode;
    logic                   changed;
    t_phase                 entry_phase;
    logic [TIMER_WIDTH-1:0] entry_rem;
    logic [REG_WIDTH-1:0]   entry_dur;
    logic                   expired;

    // next state
    always_comb begin
        sel_mode = r_mode;
        if (!i_switch_n[0]) begin
            sel_mode = MODE_NORMAL;
        end else if (!i_switch_n[1]) begin
            sel_mode = MODE_OFFLINE;
        end else if (!i_switch_n[2]) begin
            sel_mode = MODE_ALARM;
        end

        changed = r_first || (sel_mode != r_mode);

        case (sel_mode)
            MODE_OFFLINE: entry_dur = i_durations.offline;
            MODE_ALARM:   entry_dur = i_durations.alarm;
            default:      entry_dur = i_durations.red;
        endcase

        entry_phase = changed ? PH_RED : r_phase;
        entry_rem   = changed ? clip_duration(entry_dur) : r_remaining;
        expired     = (entry_rem <= TIMER_WIDTH'(1));

        n_mode      = sel_mode;
        n_phase     = entry_phase;
        n_lamps     = r_lamps;
        n_remaining = entry_rem - TIMER_WIDTH'(1);

        if (expired) begin
            case (sel_mode)
                MODE_OFFLINE, MODE_ALARM: begin
                    if (entry_phase == PH_YELLOW) begin
                        n_lamps = LAMP_OFF;
                        n_phase = PH_RED;
                    end else begin
                        n_lamps = (sel_mode == MODE_ALARM) ? (LAMP_R | LAMP_Y) : LAMP_Y;
                        n_phase = PH_YELLOW;
                    end
                    n_remaining = (sel_mode == MODE_ALARM) ?
                                  clip_duration(i_durations.alarm) :
                                  clip_duration(i_durations.offline);
                end
                default: begin
                    case (entry_phase)
                        PH_YELLOW: begin
                            n_lamps     = LAMP_G;
                            n_phase     = PH_GREEN;
                            n_remaining = clip_duration(i_durations.green);
                        end
                        PH_GREEN: begin
                            n_lamps     = LAMP_R;
                            n_phase     = PH_RED;
                            n_remaining = clip_duration(i_durations.red);
                        end
                        default: begin
                            n_lamps     = LAMP_Y;
                            n_phase     = PH_YELLOW;
                            n_remaining = clip_duration(i_durations.yellow);
                        end
                    endcase
                end
            endcase
        end
    end

    // result of this transaction
    always_comb begin
        o_result.mode    = n_mode;
        o_result.changed = changed;
        o_result.lamps   = n_lamps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_phase     <= PH_RED;
            r_lamps     <= LAMP_OFF;
            r_remaining <= '0;
            r_first     <= 1'b1;
        end else if (i_en) begin
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_lamps     <= n_lamps;
            r_remaining <= n_remaining;
            r_first     <= 1'b0;
        end
    end

endmodule

@@ src/traffic_light_mode_sequencer.sv @@
// Registered path: input register, then result register. One transaction per cycle while
// i_m_axis_tready is high; the mode/phase/countdown update is a single compare, decrement
// and select between the input and result registers.
// Reset (i_rst_n low, synchronous): durations return to defaults, normal mode, red phase,
// all lamps off, countdown zero; the first transaction is taken as entry into its mode.
module traffic_light_mode_sequencer
    import tlms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [0] normal_switch_n, [1] offline_switch_n, [2] alarm_switch_n, [7:3] zero
    input  logic [7:0]            i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] red_lamp, [1] yellow_lamp, [2] green_lamp, [3] mode_changed,
    // [5:4] active_mode, [7:6] zero
    output logic [7:0]            o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [REG_WIDTH-1:0]  i_cfg_wdata
);

    t_durations durations;
    t_result    result;

    logic       r_in_valid;
    logic [2:0] r_in_sw;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_load;
    logic       in_load;

    // advance the input stage whenever the result register is free or being drained
    assign out_load        = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || out_load;
    assign in_load         = i_s_axis_tvalid && o_s_axis_tready;

    tlms_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_durations (durations)
    );

    tlms_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (out_load),
        .i_switch_n  (r_in_sw),
        .i_durations (durations),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_sw <= i_s_axis_tdata[2:0];
        end
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.mode, r_out.changed, r_out.lamps};

endmodule

@@ dv/traffic_light_mode_sequencer_checker.sv @@
module traffic_light_mode_sequencer_checker
    import tlms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // [0] normal_switch_n, [1] offline_switch_n, [2] alarm_switch_n, [7:3] zero
    input  logic [7:0]            i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // [0] red_lamp, [1] yellow_lamp, [2] green_lamp, [3] mode_changed,
    // [5:4] active_mode, [7:6] zero
    input  logic [7:0]            i_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [REG_WIDTH-1:0]  i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    // Out-of-range mode code: makes the first tick after reset count as an entry
    localparam logic [1:0] MODE_NONE = 2'd3;

    t_durations       durations;
    t_mode            mode_q;
    logic [1:0]       entered_mode_q;
    t_phase           phase_q;
    logic [2:0]       lamps_q;
    logic [15:0]      countdown_q;
    t_result          lamp_state_queue[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [15:0] phase_ticks(input logic [REG_WIDTH-1:0] d);
        // TIMER_WIDTH matches the register width, so no saturation can occur
        return d;
    endfunction

    // Advance the lamp sequence by one expiry
    function automatic void step_lamps();
        logic [2:0] blink_on;
        if (mode_q == MODE_OFFLINE || mode_q == MODE_ALARM) begin
            blink_on = (mode_q == MODE_ALARM) ? (LAMP_R | LAMP_Y) : LAMP_Y;
            if (phase_q == PH_YELLOW) begin
                lamps_q = LAMP_OFF;
                phase_q = PH_RED;
            end else begin
                lamps_q = blink_on;
                phase_q = PH_YELLOW;
            end
            countdown_q = phase_ticks((mode_q == MODE_ALARM) ? durations.alarm
                                                              : durations.offline);
        end else begin
            case (phase_q)
                PH_YELLOW: begin
                    lamps_q     = LAMP_G;
                    phase_q     = PH_GREEN;
                    countdown_q = phase_ticks(durations.green);
                end
                PH_GREEN: begin
                    lamps_q     = LAMP_R;
                    phase_q     = PH_RED;
                    countdown_q = phase_ticks(durations.red);
                end
                default: begin
                    lamps_q     = LAMP_Y;
                    phase_q     = PH_YELLOW;
                    countdown_q = phase_ticks(durations.yellow);
                end
            endcase
        end
    endfunction

    function automatic t_result advance_tick(input logic [2:0] switches_n);
        t_result r;
        logic    entered;
        if (!switches_n[0]) begin
            mode_q = MODE_NORMAL;
        end else if (!switches_n[1]) begin
            mode_q = MODE_OFFLINE;
        end else if (!switches_n[2]) begin
            mode_q = MODE_ALARM;
        end
        entered = (2'(mode_q) != entered_mode_q);
        if (entered) begin
            entered_mode_q = 2'(mode_q);
            phase_q        = PH_RED;
            case (mode_q)
                MODE_OFFLINE: countdown_q = phase_ticks(durations.offline);
                MODE_ALARM:   countdown_q = phase_ticks(durations.alarm);
                default:      countdown_q = phase_ticks(durations.red);
            endcase
        end
        // A countdown of zero or one expires, so a zero duration acts as one
        if (countdown_q <= 16'd1) begin
            step_lamps();
        end else begin
            countdown_q = countdown_q - 16'd1;
        end
        r.mode    = mode_q;
        r.changed = entered;
        r.lamps   = lamps_q;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [1:0] want,
                                 input logic [1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            durations      = '{RED_RESET, YELLOW_RESET, GREEN_RESET, ALARM_RESET,
                               OFFLINE_RESET};
            mode_q         = MODE_NORMAL;
            entered_mode_q = MODE_NONE;
            phase_q        = PH_RED;
            lamps_q        = LAMP_OFF;
            countdown_q    = '0;
            lamp_state_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RED:     durations.red     = i_cfg_wdata;
                    REG_YELLOW:  durations.yellow  = i_cfg_wdata;
                    REG_GREEN:   durations.green   = i_cfg_wdata;
                    REG_ALARM:   durations.alarm   = i_cfg_wdata;
                    REG_OFFLINE: durations.offline = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (lamp_state_queue.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %h",
                             $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = lamp_state_queue.pop_front();
                    compare_field("red_lamp", 2'(want.lamps[0]), 2'(i_m_tdata[0]));
                    compare_field("yellow_lamp", 2'(want.lamps[1]), 2'(i_m_tdata[1]));
                    compare_field("green_lamp", 2'(want.lamps[2]), 2'(i_m_tdata[2]));
                    compare_field("mode_changed", 2'(want.changed), 2'(i_m_tdata[3]));
                    compare_field("active_mode", 2'(want.mode), i_m_tdata[5:4]);
                    compare_field("padding", 2'd0, i_m_tdata[7:6]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                lamp_state_queue.push_back(advance_tick(i_s_tdata[2:0]));
            end
        end
        o_pending = lamp_state_queue.size();
    end

endmodule

@@ dv/traffic_light_mode_sequencer_tb.sv @@
module traffic_light_mode_sequencer_tb;
    import tlms_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_BLOCK  = 100;

    localparam logic [2:0] SW_HOLD    = 3'b111;
    localparam logic [2:0] SW_NORMAL  = 3'b110;
    localparam logic [2:0] SW_OFFLINE = 3'b101;
    localparam logic [2:0] SW_ALARM   = 3'b011;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [REG_WIDTH-1:0]  cfg_wdata;
    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    int                    send_idle_pct;
    int                    recv_idle_pct;

    traffic_light_mode_sequencer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    traffic_light_mode_sequencer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("traffic_light_mode_sequencer_tb: errors");
            $finish;
        end
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold the tick until it is taken; valid stays high for a following tick
    task automatic send_tick(input logic [2:0] switches_n);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, switches_n};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Stop sending and wait for every outstanding result to drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [REG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all_regs(input logic [REG_WIDTH-1:0] value);
        for (int r = REG_RED; r <= REG_OFFLINE; r++) begin
            write_reg(CFG_ADDR_W'(r), value);
        end
    endtask

    // Mostly short phases so the lamps cycle often; the odd zero or full-scale value
    function automatic logic [REG_WIDTH-1:0] pick_ticks();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return REG_WIDTH'($urandom_range(7, 40));
            default: return REG_WIDTH'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic randomise_durations();
        for (int r = REG_RED; r <= REG_OFFLINE; r++) begin
            write_reg(CFG_ADDR_W'(r), pick_ticks());
        end
    endtask

    // Runs of a held switch pattern, so each mode lives long enough to blink
    task automatic run_random_ticks(input int count);
        int         sent;
        int         run_len;
        logic [2:0] pattern;
        sent = 0;
        while (sent < count) begin
            pattern = ($urandom_range(2) == 0) ? SW_HOLD : 3'($urandom_range(7));
            run_len = $urandom_range(1, 25);
            for (int i = 0; i < run_len; i++) begin
                if ($urandom_range(15) == 0) begin
                    send_tick(3'($urandom_range(7)));
                end else begin
                    send_tick(pattern);
                end
            end
            sent += run_len;
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_RED;
        cfg_wdata     = '0;
        send_idle_pct = 22;
        recv_idle_pct = 84;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Default durations: every switch combination, starting with all released
        for (int v = 7; v >= 0; v--) begin
            send_tick(3'(v));
        end
        settle();

        write_reg(REG_RED, 16'd1);
        write_reg(REG_YELLOW, 16'd2);
        write_reg(REG_GREEN, 16'd3);
        write_reg(REG_ALARM, 16'd1);
        write_reg(REG_OFFLINE, 16'd2);
        repeat (6) send_tick(SW_NORMAL);
        repeat (3) send_tick(SW_OFFLINE);
        repeat (3) send_tick(SW_ALARM);
        settle();

        // Zero durations expire on every tick
        write_all_regs('0);
        send_tick(SW_NORMAL);
        send_tick(SW_OFFLINE);
        send_tick(SW_ALARM);
        settle();

        write_all_regs('1);
        send_tick(SW_HOLD);
        send_tick(SW_OFFLINE);
        settle();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (2) begin
                randomise_durations();
                run_random_ticks(RANDOM_BLOCK);
                settle();
            end
        end

        if (fail_count == 0) begin
            $display("traffic_light_mode_sequencer_tb: clean");
        end else begin
            $display("traffic_light_mode_sequencer_tb: errors");
        end
        $finish;
    end

endmodule
